@@ rtl/core/sbs_pkg.sv @@
// Shared types and constants for the sequence bubble sorter.
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

    localparam int unsigned VALUE_W = 32;

    // One input item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    // One sorted result
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_res;
        logic                      overflow;
    } result_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_SORT_EVEN = 3'd2,
        OP_SORT_ODD  = 3'd3,
        OP_SHIFT_OUT = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/sequence_bubble_sorter.sv @@
// Top level of the sequence bubble sorter: control and the chain of cells.
//
//   channel   direction   handshake                  payload
//   item      in          item_valid / item_ready    item_t   {value, last}
//   result    out         result_valid / result_ready result_t {value_res, last_res, overflow}
//
// Loading takes one item per cycle; items shift into the cell chain at cell 0.
// After the item marked last, the chain runs N odd-even transposition rounds,
// one per cycle (N = stored items), then streams N results from cell 0,
// one per cycle while result_ready is high.
// Items are not taken while sorting or draining; result stalls hold the chain.
// Reset clears all valid bits, the count and the overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module sequence_bubble_sorter
    import sbs_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_SORT  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   rnd_reg;
    logic [CNT_W-1:0]   rnd_next;
    logic               phase_reg;
    logic               phase_next;
    logic               drop_reg;
    logic               drop_next;
    logic               item_xfer;
    logic               result_xfer;
    logic               room;
    cell_ctrl_t         ctrl;

    logic signed [VALUE_W-1:0] cell_val [MAX_ITEMS];
    logic                      cell_vld [MAX_ITEMS];

    assign item_ready   = (state_reg == S_LOAD);
    assign result_valid = (state_reg == S_DRAIN);
    assign item_xfer    = item_valid && item_ready;
    assign result_xfer  = result_valid && result_ready;
    assign room         = (cnt_reg < CNT_W'(MAX_ITEMS));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        phase_next = phase_reg;
        drop_next  = drop_reg;
        ctrl.op    = OP_HOLD;
        case (state_reg)
            S_LOAD:
            begin
                if (item_xfer)
                begin
                    if (room)
                    begin
                        ctrl.op  = OP_LOAD;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        rnd_next   = room ? cnt_reg + CNT_W'(1) : cnt_reg;
                        phase_next = 1'b0;
                        state_next = S_SORT;
                    end
                end
            end
            S_SORT:
            begin
                ctrl.op    = phase_reg ? OP_SORT_ODD : OP_SORT_EVEN;
                phase_next = !phase_reg;
                rnd_next   = rnd_reg - CNT_W'(1);
                if (rnd_reg == CNT_W'(1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (result_xfer)
                begin
                    ctrl.op  = OP_SHIFT_OUT;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            phase_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            phase_reg <= phase_next;
            drop_reg  <= drop_next;
        end
    end

    // Chain of cells: new items enter at cell 0, results leave from cell 0
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] l_val;
        logic                      l_vld;
        logic signed [VALUE_W-1:0] r_val;
        logic                      r_vld;

        if (i == 0)
        begin : g_first
            assign l_val = item.value;
            assign l_vld = (ctrl.op == OP_LOAD);
        end
        else
        begin : g_inner_l
            assign l_val = cell_val[i-1];
            assign l_vld = cell_vld[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_final
            assign r_val = '0;
            assign r_vld = 1'b0;
        end
        else
        begin : g_inner_r
            assign r_val = cell_val[i+1];
            assign r_vld = cell_vld[i+1];
        end

        sbs_cell #(
            .ODD_CELL (i % 2 == 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left_val  (l_val),
            .left_vld  (l_vld),
            .right_val (r_val),
            .right_vld (r_vld),
            .val       (cell_val[i]),
            .vld       (cell_vld[i])
        );
    end

    // Result straight from cell 0
    assign result.value_res = cell_val[0];
    assign result.last_res  = (cnt_reg == CNT_W'(1));
    assign result.overflow  = drop_reg;

endmodule

`default_nettype wire

@@ rtl/core/sbs_cell.sv @@
// One cell of the sorting chain: holds one element and its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module sbs_cell
    import sbs_pkg::*;
#(
    parameter bit ODD_CELL = 1'b0
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic signed [VALUE_W-1:0] left_val,
    input  wire logic                      left_vld,
    input  wire logic signed [VALUE_W-1:0] right_val,
    input  wire logic                      right_vld,
    output logic signed [VALUE_W-1:0]      val,
    output logic                           vld
);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic                      vld_reg;
    logic                      vld_next;
    logic                      lower_of_pair;
    logic                      swap_up;
    logic                      swap_down;

    // Pairing: even phase pairs (0,1),(2,3)..; odd phase pairs (1,2),(3,4)..
    assign lower_of_pair = ((ctrl.op == OP_SORT_EVEN) && !ODD_CELL) ||
                           ((ctrl.op == OP_SORT_ODD)  &&  ODD_CELL);

    // Swap only between two valid elements where the lower one is strictly greater
    assign swap_up   = vld_reg && right_vld && (val_reg > right_val);
    assign swap_down = left_vld && vld_reg && (left_val > val_reg);

    // Next element and valid bit
    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                val_next = left_val;
                vld_next = left_vld;
            end
            OP_SHIFT_OUT:
            begin
                val_next = right_val;
                vld_next = right_vld;
            end
            OP_SORT_EVEN, OP_SORT_ODD:
            begin
                if (lower_of_pair)
                begin
                    if (swap_up)
                        val_next = right_val;
                end
                else
                begin
                    if (swap_down)
                        val_next = left_val;
                end
            end
            default:
            begin
                val_next = val_reg;
                vld_next = vld_reg;
            end
        endcase
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Element payload
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

`default_nettype wire

@@ rtl/core/sbs_checker.sv @@
// Port-level checks for the sequence bubble sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sbs_checker
    import sbs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_ready,
    input  wire item_t   item,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result
);

    // A stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // No item is taken while results of a list are pending
    a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("item accepted during drain");

    // The final result ends the list
    a_last_ends_list: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last_res |=> !result_valid && item_ready)
        else $error("results continue after last");

    // Within a list results stream back to back with one overflow value
    a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_res |=>
            result_valid && (result.overflow == $past(result.overflow)))
        else $error("overflow changed within a list");

    // An item marked last is followed by a gap before input reopens
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last |=> !item_ready)
        else $error("input still open after last item");

endmodule

bind sequence_bubble_sorter sbs_checker u_sbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
